// ===== hdl/lfr_pkg.sv =====
// package with command codes for the lru frame replacer
`timescale 1ns / 1ps
package lfr_pkg;
    localparam logic [1:0] CMD_VICTIM = 2'd0;
    localparam logic [1:0] CMD_PIN    = 2'd1;
    localparam logic [1:0] CMD_UNPIN  = 2'd2;
endpackage

// ===== hdl/lfr_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps
module lfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/lru_frame_replacer_core.sv =====
// top level of the lru frame replacer: linked list of evictable frames in two rams
//
//  channel | ports                                   | direction
//  s_      | s_valid s_ready s_cmd s_frame           | command in
//  m_      | m_valid m_ready m_ok m_victim_frame     | result out
//          | m_evictable_count                       |
//
// each command steps through the states: S_IDLE takes the transfer, S_WR does the link ram
// read, S_READ decides and writes back both rams in parallel, then the result stands in the
// output register in S_OUT; a new command is taken once the result has been transferred
// aresetn is synchronous, active low; presence flags, list ends and count clear at once
// link rams need no clearing, an entry is only read once written
// a stalled result holds the block; no further command is taken
`timescale 1ns / 1ps
module lru_frame_replacer_core #(
    parameter int NUM_FRAMES = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_cmd,
    input  logic [5:0] s_frame,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_ok,
    output logic [5:0] m_victim_frame,
    output logic [6:0] m_evictable_count
);
    import lfr_pkg::*;

    localparam int AW = $clog2(NUM_FRAMES);
    localparam int CW = $clog2(NUM_FRAMES + 1);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_WR, S_OUT} state_t;
    state_t state_reg;

    logic [NUM_FRAMES-1:0] present_reg;
    logic [AW-1:0]         oldest_reg, newest_reg, tgt_reg;
    logic [CW-1:0]         count_reg;
    logic [1:0]            cmd_reg;
    logic                  fr_ok_reg, ok_reg;
    logic [5:0]            victim_reg;

    // link rams
    logic          o_we, n_we;
    logic [AW-1:0] o_wa, n_wa, o_wd, n_wd, o_rd, n_rd;
    lfr_ram #(.WIDTH(AW), .DEPTH(NUM_FRAMES)) u_older (
        .aclk(aclk), .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(tgt_reg), .rdata(o_rd));
    lfr_ram #(.WIDTH(AW), .DEPTH(NUM_FRAMES)) u_newer (
        .aclk(aclk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(tgt_reg), .rdata(n_rd));

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_ok = ok_reg;
    assign m_victim_frame = victim_reg;
    assign m_evictable_count = 7'(count_reg);

    // decision made in S_READ, once links of the target are out of the rams
    logic tgt_present, do_unlink, do_append, middle;
    always_comb begin
        tgt_present = fr_ok_reg && present_reg[tgt_reg];
        do_unlink = 1'b0;
        do_append = 1'b0;
        case (cmd_reg)
            CMD_VICTIM: do_unlink = (count_reg != '0);
            CMD_PIN:    do_unlink = tgt_present;
            CMD_UNPIN:  do_append = fr_ok_reg && !tgt_present
                                    && (count_reg != CW'(NUM_FRAMES));
            default: ;
        endcase
        middle = do_unlink && (count_reg != CW'(1)) && (tgt_reg != oldest_reg)
                 && (tgt_reg != newest_reg);
        // writes happen in S_READ using decision and ram data
        o_we = (state_reg == S_READ) && (middle || (do_append && count_reg != '0));
        n_we = o_we;
        if (do_append) begin
            n_wa = newest_reg; n_wd = tgt_reg;
            o_wa = tgt_reg;    o_wd = newest_reg;
        end else begin
            n_wa = o_rd;       n_wd = n_rd;
            o_wa = n_rd;       o_wd = o_rd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            present_reg <= '0;
            oldest_reg  <= '0;
            newest_reg  <= '0;
            count_reg   <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: if (s_valid) begin
                    cmd_reg   <= s_cmd;
                    // victim needs no frame number, the oldest end is always in range
                    fr_ok_reg <= (s_cmd == CMD_VICTIM) || (32'(s_frame) < NUM_FRAMES);
                    tgt_reg   <= (s_cmd == CMD_VICTIM) ? oldest_reg : AW'(s_frame);
                    state_reg <= S_WR;
                end
                S_WR: state_reg <= S_READ; // ram read lands
                S_READ: begin
                    ok_reg     <= do_unlink || do_append;
                    victim_reg <= (cmd_reg == CMD_VICTIM && do_unlink) ? 6'(tgt_reg) : 6'd0;
                    if (do_unlink) begin
                        present_reg[tgt_reg] <= 1'b0;
                        count_reg <= count_reg - CW'(1);
                        if (count_reg == CW'(1)) begin
                            oldest_reg <= '0; newest_reg <= '0;
                        end else if (tgt_reg == oldest_reg) oldest_reg <= n_rd;
                        else if (tgt_reg == newest_reg) newest_reg <= o_rd;
                    end else if (do_append) begin
                        present_reg[tgt_reg] <= 1'b1;
                        count_reg <= count_reg + CW'(1);
                        if (count_reg == '0) oldest_reg <= tgt_reg;
                        newest_reg <= tgt_reg;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: if (m_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // count tracks the flags
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(present_reg) == 32'(count_reg))
        else $error("count mismatch");
    a_victim: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_victim_frame != 6'd0 |-> m_ok)
        else $error("victim without ok");
    a_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid)
        else $error("result too early");
endmodule
